/* design/cle_pkg.sv */
// ----------------------------------------------------------------------------
// Console line editor package
// Shared constants, key codes, result kinds, state codes and request types.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int LINE_BYTES   = 64;
  localparam int RECALL_LIMIT = 60;
  localparam int ADDR_W       = $clog2(LINE_BYTES);
  localparam int LEN_W        = ADDR_W + 1;

  localparam logic [7:0] KEY_CTRLQ = 8'h11;
  localparam logic [7:0] KEY_CTRLS = 8'h13;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_NUL   = 8'h00;

  localparam logic       CMD_CHAR = 1'b0;
  localparam logic       CMD_READ = 1'b1;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ERASE,
    S_CRLF,
    S_TAB,
    S_DONE,
    S_COPY,
    S_FINISH
  } cle_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_in;
    logic [5:0] read_index;
  } cle_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [6:0] line_length;
    logic       last;
  } cle_out_t;

  typedef struct packed {
    logic     push;
    logic     flush;
    cle_out_t res;
  } cle_gen_t;

endpackage

/* design/console_line_editor_unit.sv */
// ----------------------------------------------------------------------------
// Console line editor unit
// Builds a text line from received characters, echoes, erases, aborts,
// completes lines and replays the previous line; reads back line bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_req when start is high and busy is low. Each result
//   appears on out_res for one cycle with out_strobe high; last marks the
//   final result of a request. The receiver cannot stall the unit.
//   cfg_data sets echo_plain on cfg_valid; cfg_ready is always high.
// Sequencing:
//   A result is held in a pending register until the next result or the
//   closing flush moves it to the output register. A plain character goes
//   through accept and finish, a read through accept, read and finish, an
//   erase through accept, backspace, space, backspace and finish. Recall
//   replay copies one replayed byte per cycle from the recall memory read
//   port. Completing a line adds a step to close the line and a copy of it
//   through the line memory read port into the recall memory.
// Reset:
//   Empty line, nothing to recall, echo_plain set. Both memories hold
//   unknown data until written; no clearing pass is run.
// ----------------------------------------------------------------------------
module console_line_editor_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cle_pkg::cle_in_t  in_req,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output logic              out_strobe,
  output cle_pkg::cle_out_t out_res
);
  import cle_pkg::*;

  cle_state_t state_r, state_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] recall_len_r, recall_len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             echo_plain_r;

  logic [7:0]        line_mem [LINE_BYTES];
  logic [7:0]        recall_mem [LINE_BYTES];
  logic [7:0]        line_rd_r, recall_rd_r;
  logic              line_we, recall_we;
  logic [ADDR_W-1:0] line_wa, line_ra, recall_wa, recall_ra;
  logic [7:0]        line_wd, recall_wd;

  cle_gen_t         gen;
  logic [LEN_W-1:0] fill_inc;
  logic [LEN_W-1:0] idx_inc;
  logic [7:0]       echo_chr;
  logic             tab_go;

  assign fill_inc  = fill_r + LEN_W'(1);
  assign idx_inc   = idx_r + LEN_W'(1);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    recall_len_nxt = recall_len_r;
    idx_nxt        = idx_r;
    line_we        = 1'b0;
    line_wa        = fill_r[ADDR_W-1:0];
    line_wd        = CHR_NUL;
    line_ra        = idx_inc[ADDR_W-1:0];
    recall_we      = 1'b0;
    recall_wa      = idx_r[ADDR_W-1:0];
    recall_wd      = line_rd_r;
    recall_ra      = idx_inc[ADDR_W-1:0];
    gen            = '0;
    echo_chr       = CHR_STAR;
    tab_go         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req.cmd == CMD_READ) begin
            line_ra   = in_req.read_index;
            state_nxt = S_READ;
          end else begin
            echo_chr = echo_plain_r ? in_req.char_in : CHR_STAR;
            case (in_req.char_in) inside
              KEY_CTRLQ, KEY_CTRLS: begin
                state_nxt = S_IDLE;
              end
              KEY_BS, KEY_DEL: begin
                if (fill_r != '0) begin
                  fill_nxt  = fill_r - LEN_W'(1);
                  idx_nxt   = '0;
                  state_nxt = S_ERASE;
                end
              end
              KEY_ESC: begin
                line_we            = 1'b1;
                line_wd            = CHR_NUL;
                fill_nxt           = '0;
                gen.push           = 1'b1;
                gen.res.kind       = KIND_ABORT;
                state_nxt          = S_FINISH;
              end
              KEY_TAB: begin
                idx_nxt   = '0;
                recall_ra = '0;
                state_nxt = S_TAB;
              end
              KEY_CR: begin
                line_we   = 1'b1;
                line_wd   = KEY_CR;
                fill_nxt  = fill_inc;
                state_nxt = S_CRLF;
              end
              default: begin
                line_we           = 1'b1;
                line_wd           = in_req.char_in;
                fill_nxt          = fill_inc;
                gen.push          = 1'b1;
                gen.res.kind      = KIND_ECHO;
                gen.res.data_byte = echo_chr;
                if (in_req.char_in == KEY_LF || fill_inc >= LEN_W'(LINE_BYTES - 2)) begin
                  state_nxt = S_DONE;
                end else begin
                  state_nxt = S_FINISH;
                end
              end
            endcase
          end
        end
      end

      S_READ: begin
        gen.push          = 1'b1;
        gen.res.kind      = KIND_READ;
        gen.res.data_byte = line_rd_r;
        state_nxt         = S_FINISH;
      end

      S_ERASE: begin
        gen.push          = 1'b1;
        gen.res.kind      = KIND_ECHO;
        gen.res.data_byte = (idx_r == LEN_W'(1)) ? CHR_SPACE : KEY_BS;
        idx_nxt           = idx_inc;
        if (idx_r == LEN_W'(2)) begin
          state_nxt = S_FINISH;
        end
      end

      S_CRLF: begin
        line_we           = 1'b1;
        line_wd           = KEY_LF;
        fill_nxt          = fill_inc;
        gen.push          = 1'b1;
        gen.res.kind      = KIND_ECHO;
        gen.res.data_byte = echo_plain_r ? KEY_LF : CHR_STAR;
        state_nxt         = S_DONE;
      end

      S_TAB: begin
        tab_go = (idx_r < recall_len_r) && (idx_r < LEN_W'(LINE_BYTES))
                 && (recall_rd_r != KEY_CR) && (recall_rd_r != KEY_LF)
                 && (recall_rd_r != CHR_NUL)
                 && (fill_r < LEN_W'(RECALL_LIMIT))
                 && (fill_r < LEN_W'(LINE_BYTES - 2));
        if (tab_go) begin
          line_we           = 1'b1;
          line_wd           = recall_rd_r;
          fill_nxt          = fill_inc;
          gen.push          = 1'b1;
          gen.res.kind      = KIND_ECHO;
          gen.res.data_byte = echo_plain_r ? recall_rd_r : CHR_STAR;
          idx_nxt           = idx_inc;
          recall_ra         = idx_inc[ADDR_W-1:0];
        end else if (fill_r >= LEN_W'(LINE_BYTES - 2)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      S_DONE: begin
        line_we             = 1'b1;
        line_wd             = CHR_NUL;
        recall_len_nxt      = fill_r;
        gen.push            = 1'b1;
        gen.res.kind        = KIND_DONE;
        gen.res.line_length = fill_r;
        fill_nxt            = '0;
        idx_nxt             = '0;
        line_ra             = '0;
        state_nxt           = S_COPY;
      end

      S_COPY: begin
        if (idx_r < recall_len_r) begin
          recall_we = 1'b1;
          recall_wa = idx_r[ADDR_W-1:0];
          recall_wd = line_rd_r;
          line_ra   = idx_inc[ADDR_W-1:0];
          idx_nxt   = idx_inc;
        end else begin
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        gen.flush = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      recall_len_r <= '0;
      idx_r        <= '0;
      echo_plain_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      recall_len_r <= recall_len_nxt;
      idx_r        <= idx_nxt;
      if (cfg_valid && cfg_ready) begin
        echo_plain_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
    line_rd_r <= line_mem[line_ra];
  end

  always_ff @(posedge clk) begin
    if (recall_we) begin
      recall_mem[recall_wa] <= recall_wd;
    end
    recall_rd_r <= recall_mem[recall_ra];
  end

  cle_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .gen        (gen),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

/* design/cle_out_stage.sv */
// ----------------------------------------------------------------------------
// Console line editor result stage
// Holds one pending result so the final one of a request carries the last flag.
// ----------------------------------------------------------------------------
module cle_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  cle_pkg::cle_gen_t gen,
  output logic              out_strobe,
  output cle_pkg::cle_out_t out_res
);
  import cle_pkg::*;

  logic     pend_v_r, pend_v_nxt;
  cle_out_t pend_r, pend_nxt;
  logic     strobe_r, strobe_nxt;
  cle_out_t res_r, res_nxt;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    if (gen.push) begin
      if (pend_v_r) begin
        strobe_nxt   = 1'b1;
        res_nxt      = pend_r;
        res_nxt.last = 1'b0;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = gen.res;
    end else if (gen.flush && pend_v_r) begin
      strobe_nxt   = 1'b1;
      res_nxt      = pend_r;
      res_nxt.last = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule
